// ===== rtl/core/plst_pkg.sv =====
`default_nettype none

package plst_pkg;

    // Default sizes of the list.
    localparam int unsigned CAPACITY_DEF   = 32;
    localparam int unsigned ITEM_WIDTH_DEF = 64;

    // Fixed field widths of the request and result items.
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned LEN_W    = 6;

    // Request kinds; the fourth code is unused and always fails.
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT   = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_RETRIEVE = 2'd2
    } act_t;

    // Broadcast to every cell of the row for one accepted item.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] slot;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/plst_req_if.sv =====
`default_nettype none

interface plst_req_if
    import plst_pkg::*;
#(
    parameter int unsigned IW = ITEM_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [IW-1:0]       item_in;

    modport source (output valid, output action, output position, output item_in,
                    input ready);
    modport sink   (input valid, input action, input position, input item_in,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/plst_rsp_if.sv =====
`default_nettype none

interface plst_rsp_if
    import plst_pkg::*;
#(
    parameter int unsigned IW = ITEM_WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic             ok;
    logic [IW-1:0]    item_out;
    logic [LEN_W-1:0] length;

    modport source (output valid, output ok, output item_out, output length,
                    input ready);
    modport sink   (input valid, input ok, input item_out, input length,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/plst_cell.sv =====
`default_nettype none

module plst_cell
    import plst_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned IW  = ITEM_WIDTH_DEF
)(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [IW-1:0] new_item,
    input  wire logic [IW-1:0] left,
    input  wire logic [IW-1:0] right,
    output logic [IW-1:0]   data
);

    logic [IW-1:0] data_reg;
    logic [IW-1:0] data_next;
    logic          at_slot;
    logic          past_slot;

    // Where this cell sits relative to the slot being changed.
    assign at_slot   = (32'(ctrl.slot) == IDX);
    assign past_slot = (32'(ctrl.slot) < IDX);

    // Insert: load at the slot, take from the left beyond it.
    // Delete: take from the right from the slot onwards.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (at_slot)
                data_next = new_item;
            else if (past_slot)
                data_next = left;
        end
        else if (ctrl.del)
        begin
            if (at_slot || past_slot)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_store.sv =====
// Channel | Dir | Handshake      | Payload
// req     | in  | valid / ready  | action, position, item_in
// rsp     | out | valid / ready  | ok, item_out, length
//
// On acceptance the row of cells shifts in parallel and the result lands in an output
// register, so one item per cycle is sustained while rsp does not stall.
// A new item is taken while the held result is being taken or the register is empty.
// A stall on rsp holds the result and stops req; no result is dropped.
// Reset clears the length and the output valid; the cell contents stay undefined.
`default_nettype none

module positional_list_store
    import plst_pkg::*;
#(
    parameter int unsigned CAPACITY   = CAPACITY_DEF,
    parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    plst_req_if.sink   req,
    plst_rsp_if.source rsp
);

    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  rsp_valid_reg;
    logic                  rsp_ok_reg;
    logic [ITEM_WIDTH-1:0] rsp_item_reg;
    logic [LEN_W-1:0]      rsp_len_reg;

    logic                  accept;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      len_ext;
    logic                  pos_nonzero;
    logic                  in_list;
    logic                  ins_ok;
    logic                  del_ok;
    logic                  ok_next;
    logic [ITEM_WIDTH-1:0] item_next;
    logic [ITEM_WIDTH-1:0] read_data;
    logic [POS_W-1:0]      slot;
    cell_ctrl_t            ctrl;
    act_t                  act;

    logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];

    assign accept = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    // Range checks of the position against the current length.
    assign pos_ext     = CMP_W'(req.position);
    assign cnt_ext     = CMP_W'(cnt_reg);
    assign pos_nonzero = (req.position != '0);
    assign in_list     = pos_nonzero && (pos_ext <= cnt_ext);
    assign ins_ok      = pos_nonzero && (pos_ext <= cnt_ext + CMP_W'(1))
                         && (cnt_reg != CW'(CAPACITY));
    assign del_ok      = in_list;
    assign slot        = req.position - POS_W'(1);
    assign act         = act_t'(req.action);

    // Selected cell for a retrieve.
    always_comb
    begin
        read_data = '0;
        for (int unsigned i = 0; i < CAPACITY; i++)
        begin
            if (32'(slot) == i)
                read_data = read_data | cell_data[i];
        end
    end

    // Decode the request into the row's control and the result.
    always_comb
    begin
        ctrl      = '{ins: 1'b0, del: 1'b0, slot: slot};
        cnt_next  = cnt_reg;
        ok_next   = 1'b0;
        item_next = '0;
        unique case (act)
            ACT_INSERT:
            begin
                ok_next  = ins_ok;
                ctrl.ins = accept && ins_ok;
                if (ins_ok)
                    cnt_next = cnt_reg + CW'(1);
            end
            ACT_DELETE:
            begin
                ok_next  = del_ok;
                ctrl.del = accept && del_ok;
                if (del_ok)
                    cnt_next = cnt_reg - CW'(1);
            end
            ACT_RETRIEVE:
            begin
                ok_next = in_list;
                if (in_list)
                    item_next = read_data;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign len_ext = CMP_W'(cnt_next);

    // The row of cells, each handing its item to a neighbour on a shift.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] left_in;
        logic [ITEM_WIDTH-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = req.item_in;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[g+1];
        end

        plst_cell #(
            .IDX (g),
            .IW  (ITEM_WIDTH)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .new_item (req.item_in),
            .left     (left_in),
            .right    (right_in),
            .data     (cell_data[g])
        );
    end

    // Length and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                cnt_reg <= cnt_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_ok_reg   <= ok_next;
            rsp_item_reg <= item_next;
            rsp_len_reg  <= len_ext[LEN_W-1:0];
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.ok       = rsp_ok_reg;
    assign rsp.item_out = rsp_item_reg;
    assign rsp.length   = rsp_len_reg;

endmodule

`default_nettype wire
